>>> rtl/saic_pkg.sv
// ----------------------------------------------------------------------------
// saic_pkg
// Types and constants shared by the set-associative instruction cache.
// ----------------------------------------------------------------------------
package saic_pkg;

    localparam int NUM_SETS   = 32;
    localparam int NUM_WAYS   = 2;
    localparam int LINE_BYTES = 32;

    localparam int LINE_WORDS = LINE_BYTES / 4;
    localparam int SET_W      = $clog2(NUM_SETS);
    localparam int WAY_W      = $clog2(NUM_WAYS);
    localparam int WORD_W     = $clog2(LINE_WORDS);
    localparam int OFS_W      = $clog2(LINE_BYTES);
    localparam int TAG_W      = 32 - OFS_W;
    localparam int ROW_W      = SET_W + WORD_W;

    typedef logic [1:0]       mode_t;
    typedef logic [2:0]       status_t;
    typedef logic [TAG_W-1:0] tag_t;

    localparam mode_t MODE_FETCH      = 2'd0;
    localparam mode_t MODE_FILL       = 2'd1;
    localparam mode_t MODE_FLUSH_ALL  = 2'd2;
    localparam mode_t MODE_FLUSH_LINE = 2'd3;

    localparam status_t ST_HIT     = 3'd0;
    localparam status_t ST_MISS    = 3'd1;
    localparam status_t ST_ACCEPT  = 3'd2;
    localparam status_t ST_FILLED  = 3'd3;
    localparam status_t ST_FAULT   = 3'd4;
    localparam status_t ST_FLUSHED = 3'd5;

    localparam logic [31:0] SEED_MUL   = 32'd214013;
    localparam logic [31:0] SEED_INC   = 32'd2531011;
    localparam logic [31:0] SEED_RESET = 32'd1;

endpackage

>>> rtl/saic_in_if.sv
// ----------------------------------------------------------------------------
// saic_in_if
// Request channel of the instruction cache: fetch, fill word or flush.
// ----------------------------------------------------------------------------
interface saic_in_if;

    logic              valid;
    logic              ready;
    saic_pkg::mode_t   mode;
    logic [31:0]       address;
    logic [31:0]       fill_data;
    logic              fill_error;

    modport source (
        output valid,
        output mode,
        output address,
        output fill_data,
        output fill_error,
        input  ready
    );

    modport sink (
        input  valid,
        input  mode,
        input  address,
        input  fill_data,
        input  fill_error,
        output ready
    );

endinterface

>>> rtl/saic_out_if.sv
// ----------------------------------------------------------------------------
// saic_out_if
// Response channel of the instruction cache: status, word and victim way.
// ----------------------------------------------------------------------------
interface saic_out_if;

    logic              valid;
    logic              ready;
    saic_pkg::status_t status;
    logic [31:0]       instruction;
    logic              victim_way;

    modport source (
        output valid,
        output status,
        output instruction,
        output victim_way,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  instruction,
        input  victim_way,
        output ready
    );

endinterface

>>> rtl/set_assoc_icache_random_replace.sv
// ----------------------------------------------------------------------------
// set_assoc_icache_random_replace
// Two-way set-associative, virtually tagged instruction cache with random
// replacement driven by a linear congruential generator.
// ----------------------------------------------------------------------------
// An accepted transaction is registered in the lookup stage; its response
// is registered when it retires, which waits while the sink still holds
// the response register. A new transaction waits until the current one
// retires, due to the synchronous tag and data reads before the write-back.
// Reset clears all valid bits at once and loads the seed with one; the tag
// and data memories are not cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module set_assoc_icache_random_replace (
    input  logic       clk,
    input  logic       rst_n,
    saic_in_if.sink    in_item,
    saic_out_if.source out_item
);

    localparam int NUM_SETS   = saic_pkg::NUM_SETS;
    localparam int NUM_WAYS   = saic_pkg::NUM_WAYS;
    localparam int LINE_WORDS = saic_pkg::LINE_WORDS;
    localparam int SET_W      = saic_pkg::SET_W;
    localparam int WAY_W      = saic_pkg::WAY_W;
    localparam int WORD_W     = saic_pkg::WORD_W;
    localparam int OFS_W      = saic_pkg::OFS_W;
    localparam int ROW_W      = saic_pkg::ROW_W;

    saic_pkg::tag_t tag_mem  [NUM_SETS][NUM_WAYS];
    logic [31:0]    data_mem [2**ROW_W][NUM_WAYS];

    logic                                busy_reg;
    logic                                busy_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [31:0]                         seed_reg;
    logic [31:0]                         seed_next;
    logic [WAY_W-1:0]                    pend_way_reg;
    logic [WAY_W-1:0]                    pend_way_next;
    saic_pkg::tag_t                      pend_tag_reg;
    saic_pkg::tag_t                      pend_tag_next;
    logic [NUM_SETS-1:0][NUM_WAYS-1:0]   valid_reg;
    logic [NUM_SETS-1:0][NUM_WAYS-1:0]   valid_next;

    saic_pkg::mode_t                     mode_reg;
    logic [31:0]                         addr_reg;
    logic [31:0]                         fill_data_reg;
    logic                                fill_error_reg;
    saic_pkg::tag_t                      tag_rd_reg [NUM_WAYS];
    logic [31:0]                         data_rd_reg [NUM_WAYS];

    saic_pkg::status_t                   status_reg;
    logic [31:0]                         instr_reg;
    logic                                victim_reg;

    logic                                accept;
    logic                                retire;
    logic [SET_W-1:0]                    in_set;
    logic [WORD_W-1:0]                   in_word;
    saic_pkg::tag_t                      cur_tag;
    logic [SET_W-1:0]                    cur_set;
    logic [WORD_W-1:0]                   cur_word;
    logic [SET_W-1:0]                    pend_set;
    logic [NUM_WAYS-1:0]                 match;
    logic                                hit;
    logic [WAY_W-1:0]                    hit_way;
    logic [31:0]                         seed_prod;
    logic                                tag_we;
    logic                                data_we;
    saic_pkg::status_t                   status_c;
    logic [31:0]                         instr_c;
    logic                                victim_c;

    assign in_item.ready = !busy_reg;
    assign accept        = in_item.valid && in_item.ready;
    assign retire        = busy_reg && (!out_valid_reg || out_item.ready);

    assign in_set   = in_item.address[OFS_W +: SET_W];
    assign in_word  = in_item.address[2 +: WORD_W];
    assign cur_tag  = addr_reg[31:OFS_W];
    assign cur_set  = addr_reg[OFS_W +: SET_W];
    assign cur_word = addr_reg[2 +: WORD_W];
    assign pend_set = pend_tag_reg[SET_W-1:0];

    assign seed_prod = seed_reg * saic_pkg::SEED_MUL + saic_pkg::SEED_INC;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg       <= in_item.mode;
            addr_reg       <= in_item.address;
            fill_data_reg  <= in_item.fill_data;
            fill_error_reg <= in_item.fill_error;
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                tag_rd_reg[w]  <= tag_mem[in_set][w];
                data_rd_reg[w] <= data_mem[{in_set, in_word}][w];
            end
        end
        if (tag_we)
        begin
            tag_mem[pend_set][pend_way_reg] <= pend_tag_reg;
        end
        if (data_we)
        begin
            data_mem[{pend_set, cur_word}][pend_way_reg] <= fill_data_reg;
        end
    end

    always_comb
    begin
        match   = '0;
        hit     = 1'b0;
        hit_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            match[w] = valid_reg[cur_set][w] && (tag_rd_reg[w] == cur_tag);
            if (match[w])
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        seed_next     = seed_reg;
        pend_way_next = pend_way_reg;
        pend_tag_next = pend_tag_reg;
        valid_next    = valid_reg;
        tag_we        = 1'b0;
        data_we       = 1'b0;
        status_c      = saic_pkg::ST_FLUSHED;
        instr_c       = '0;
        victim_c      = 1'b0;
        if (retire)
        begin
            case (mode_reg)
                saic_pkg::MODE_FETCH:
                begin
                    if (hit)
                    begin
                        status_c = saic_pkg::ST_HIT;
                        instr_c  = data_rd_reg[hit_way];
                    end
                    else
                    begin
                        seed_next     = seed_prod;
                        pend_way_next = seed_prod[WAY_W-1:0];
                        pend_tag_next = cur_tag;
                        victim_c      = seed_prod[0];
                        status_c      = saic_pkg::ST_MISS;
                    end
                end
                saic_pkg::MODE_FILL:
                begin
                    valid_next[pend_set][pend_way_reg] = 1'b0;
                    if (fill_error_reg)
                    begin
                        status_c = saic_pkg::ST_FAULT;
                    end
                    else
                    begin
                        data_we = 1'b1;
                        if (cur_word == WORD_W'(LINE_WORDS - 1))
                        begin
                            tag_we                             = 1'b1;
                            valid_next[pend_set][pend_way_reg] = 1'b1;
                            status_c                           = saic_pkg::ST_FILLED;
                        end
                        else
                        begin
                            status_c = saic_pkg::ST_ACCEPT;
                        end
                    end
                end
                saic_pkg::MODE_FLUSH_ALL:
                begin
                    valid_next = '0;
                end
                saic_pkg::MODE_FLUSH_LINE:
                begin
                    for (int w = 0; w < NUM_WAYS; w++)
                    begin
                        if (match[w])
                        begin
                            valid_next[cur_set][w] = 1'b0;
                        end
                    end
                end
                default:
                begin
                    status_c = saic_pkg::ST_FLUSHED;
                end
            endcase
        end
    end

    assign busy_next      = accept ? 1'b1 : (retire ? 1'b0 : busy_reg);
    assign out_valid_next = retire ? 1'b1 : (out_item.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= saic_pkg::SEED_RESET;
            pend_way_reg  <= '0;
            pend_tag_reg  <= '0;
            valid_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            seed_reg      <= seed_next;
            pend_way_reg  <= pend_way_next;
            pend_tag_reg  <= pend_tag_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            status_reg <= status_c;
            instr_reg  <= instr_c;
            victim_reg <= victim_c;
        end
    end

    assign out_item.valid       = out_valid_reg;
    assign out_item.status      = status_reg;
    assign out_item.instruction = instr_reg;
    assign out_item.victim_way  = victim_reg;

    // A pending miss response always reports the victim that the current seed names.
    a_victim_from_seed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == saic_pkg::ST_MISS)
        |-> (victim_reg == seed_reg[0]))
        else $error("victim way does not follow the seed");

    // Only a hit carries an instruction word.
    a_instr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != saic_pkg::ST_HIT)
        |-> (instr_reg == '0))
        else $error("instruction word on a response that is not a hit");

    // A completed fill leaves the pending line valid, a faulted one invalid.
    a_filled_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == saic_pkg::ST_FILLED)
        |-> valid_reg[pend_set][pend_way_reg])
        else $error("filled line is not valid");

    a_fault_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == saic_pkg::ST_FAULT)
        |-> !valid_reg[pend_set][pend_way_reg])
        else $error("faulted line is still valid");

    // Every accepted transaction is held in the lookup stage for the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && !retire || $past(accept) && busy_reg)
        else $error("accepted transaction was not held for lookup");

endmodule

>>> sim/set_assoc_icache_random_replace_tb.sv
// ----------------------------------------------------------------------------
// set_assoc_icache_random_replace_tb
// Self-checking testbench for the two-way set-associative instruction cache.
// A directed table covers reset state, line fills, hits, unaligned fetches,
// fill faults and both flush kinds. Random miss/refill sequences, flushes and
// noise follow. Transactions without a fixed expectation are checked against
// a cycle-free model of the cache while both channels stall in random bursts.
// ----------------------------------------------------------------------------
module set_assoc_icache_random_replace_tb;

    localparam int NUM_LINES      = saic_pkg::NUM_SETS * saic_pkg::NUM_WAYS;
    localparam int LINE_WORDS     = saic_pkg::LINE_WORDS;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int CALM_TAIL      = 150;
    localparam int PRESSURE_AT    = 300;
    localparam int PRESSURE_HOLD  = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        saic_pkg::status_t status;
        logic [31:0]       instruction;
        logic              victim_way;
    } response_t;

    typedef struct packed {
        saic_pkg::mode_t   mode;
        logic [31:0]       address;
        logic [31:0]       fill_data;
        logic              fill_error;
        logic              typed;
        saic_pkg::status_t status;
        logic [31:0]       instruction;
        logic              victim_way;
    } step_t;

    localparam int DIRECTED_ROWS = 28;
    localparam step_t DIRECTED_STEPS [DIRECTED_ROWS] = '{
        '{saic_pkg::MODE_FILL, 32'h0000_0004, 32'h1111_1111, 1'b0,
          1'b1, saic_pkg::ST_ACCEPT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FETCH, 32'h0000_0000, 32'h0000_0000, 1'b0,
          1'b1, saic_pkg::ST_MISS, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'h0000_0000, 32'h0000_0000, 1'b0,
          1'b1, saic_pkg::ST_ACCEPT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'h0000_0004, 32'hFFFF_FFFF, 1'b0,
          1'b1, saic_pkg::ST_ACCEPT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'h0000_0008, 32'hA5A5_A5A5, 1'b0,
          1'b1, saic_pkg::ST_ACCEPT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'h0000_000C, 32'h5A5A_5A5A, 1'b0,
          1'b1, saic_pkg::ST_ACCEPT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'h0000_0010, 32'h8000_0000, 1'b0,
          1'b1, saic_pkg::ST_ACCEPT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'h0000_0014, 32'h0000_0001, 1'b0,
          1'b1, saic_pkg::ST_ACCEPT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'h0000_0018, 32'h1234_5678, 1'b0,
          1'b1, saic_pkg::ST_ACCEPT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'h0000_001C, 32'h89AB_CDEF, 1'b0,
          1'b1, saic_pkg::ST_FILLED, 32'h0, 1'b0},
        '{saic_pkg::MODE_FETCH, 32'h0000_0000, 32'h0000_0000, 1'b0,
          1'b1, saic_pkg::ST_HIT, 32'h0000_0000, 1'b0},
        '{saic_pkg::MODE_FETCH, 32'h0000_001F, 32'h0000_0000, 1'b0,
          1'b1, saic_pkg::ST_HIT, 32'h89AB_CDEF, 1'b0},
        '{saic_pkg::MODE_FETCH, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0,
          1'b0, saic_pkg::ST_MISS, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'h2468_ACE0, 32'hFFFF_FFFF, 1'b0,
          1'b0, saic_pkg::ST_ACCEPT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'hFFFF_FFE6, 32'h0000_0000, 1'b0,
          1'b0, saic_pkg::ST_ACCEPT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'h0000_0008, 32'hCAFE_F00D, 1'b0,
          1'b0, saic_pkg::ST_ACCEPT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'h8000_000F, 32'h0F0F_0F0F, 1'b0,
          1'b0, saic_pkg::ST_ACCEPT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'h1357_9B10, 32'hF0F0_F0F0, 1'b0,
          1'b0, saic_pkg::ST_ACCEPT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'hFFFF_FFF4, 32'h7FFF_FFFF, 1'b0,
          1'b0, saic_pkg::ST_ACCEPT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'h7FFF_FFFB, 32'h3C3C_C3C3, 1'b0,
          1'b0, saic_pkg::ST_ACCEPT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'hFFFF_FFFF, 32'hFEDC_BA98, 1'b0,
          1'b0, saic_pkg::ST_FILLED, 32'h0, 1'b0},
        '{saic_pkg::MODE_FETCH, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0,
          1'b1, saic_pkg::ST_HIT, 32'hFEDC_BA98, 1'b0},
        '{saic_pkg::MODE_FLUSH_LINE, 32'hFFFF_FFE0, 32'h0000_0000, 1'b0,
          1'b1, saic_pkg::ST_FLUSHED, 32'h0, 1'b0},
        '{saic_pkg::MODE_FETCH, 32'hFFFF_FFF0, 32'h0000_0000, 1'b0,
          1'b0, saic_pkg::ST_MISS, 32'h0, 1'b0},
        '{saic_pkg::MODE_FILL, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1,
          1'b1, saic_pkg::ST_FAULT, 32'h0, 1'b0},
        '{saic_pkg::MODE_FETCH, 32'h0000_0012, 32'h0000_0000, 1'b0,
          1'b1, saic_pkg::ST_HIT, 32'h8000_0000, 1'b0},
        '{saic_pkg::MODE_FLUSH_ALL, 32'h0000_0000, 32'h0000_0000, 1'b0,
          1'b1, saic_pkg::ST_FLUSHED, 32'h0, 1'b0},
        '{saic_pkg::MODE_FETCH, 32'h0000_0010, 32'h0000_0000, 1'b0,
          1'b0, saic_pkg::ST_MISS, 32'h0, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;

    saic_in_if  in_bus ();
    saic_out_if out_bus ();

    set_assoc_icache_random_replace u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_bus),
        .out_item (out_bus)
    );

    // Shadow copy of the cache contents and refill state.
    saic_pkg::tag_t              tag_mem      [NUM_LINES];
    logic                        line_valid   [NUM_LINES];
    logic [31:0]                 word_mem     [NUM_LINES*LINE_WORDS];
    bit                          word_written [NUM_LINES*LINE_WORDS];
    logic [31:0]                 lcg_state;
    logic [saic_pkg::WAY_W-1:0]  refill_way;
    saic_pkg::tag_t              refill_tag;

    response_t         expected_responses [$];
    saic_pkg::status_t last_status;
    int unsigned       n_sent;
    int unsigned       idle_pct;
    int unsigned       errors;
    int unsigned       quiet_cycles;
    bit                held_off;
    logic [21:0]       tag_bases [4];

    always #5 clk = ~clk;

    function automatic void clear_cache_model();
        for (int i = 0; i < NUM_LINES; i++)
        begin
            line_valid[i] = 1'b0;
            tag_mem[i]    = '0;
        end
        for (int i = 0; i < NUM_LINES*LINE_WORDS; i++)
        begin
            word_mem[i]     = '0;
            word_written[i] = 1'b0;
        end
        lcg_state  = saic_pkg::SEED_RESET;
        refill_way = '0;
        refill_tag = '0;
    endfunction

    function automatic bit hits_unwritten_word(logic [31:0] addr);
        saic_pkg::tag_t lno;
        int             slot;
        int             word_i;
        lno    = addr[31:saic_pkg::OFS_W];
        word_i = int'(addr[saic_pkg::OFS_W-1:2]);
        for (int w = 0; w < saic_pkg::NUM_WAYS; w++)
        begin
            slot = int'(lno[saic_pkg::SET_W-1:0]) * saic_pkg::NUM_WAYS + w;
            if (line_valid[slot] && tag_mem[slot] == lno)
                return !word_written[slot*LINE_WORDS + word_i];
        end
        return 1'b0;
    endfunction

    function automatic response_t predict_response(saic_pkg::mode_t m, logic [31:0] addr,
                                                   logic [31:0] data, logic err);
        response_t      r;
        saic_pkg::tag_t lno;
        int             slot;
        int             word_i;
        bit             found;
        r      = '{status: saic_pkg::ST_FLUSHED, instruction: 32'h0, victim_way: 1'b0};
        lno    = addr[31:saic_pkg::OFS_W];
        word_i = int'(addr[saic_pkg::OFS_W-1:2]);
        found  = 1'b0;
        case (m)
            saic_pkg::MODE_FETCH:
            begin
                for (int w = 0; w < saic_pkg::NUM_WAYS; w++)
                begin
                    slot = int'(lno[saic_pkg::SET_W-1:0]) * saic_pkg::NUM_WAYS + w;
                    if (!found && line_valid[slot] && tag_mem[slot] == lno)
                    begin
                        found         = 1'b1;
                        r.instruction = word_mem[slot*LINE_WORDS + word_i];
                    end
                end
                if (found)
                    r.status = saic_pkg::ST_HIT;
                else
                begin
                    lcg_state    = lcg_state * saic_pkg::SEED_MUL + saic_pkg::SEED_INC;
                    refill_way   = lcg_state[saic_pkg::WAY_W-1:0];
                    refill_tag   = lno;
                    r.victim_way = refill_way[0];
                    r.status     = saic_pkg::ST_MISS;
                end
            end
            saic_pkg::MODE_FILL:
            begin
                slot             = int'(refill_tag[saic_pkg::SET_W-1:0]) * saic_pkg::NUM_WAYS
                                 + int'(refill_way);
                line_valid[slot] = 1'b0;
                if (err)
                    r.status = saic_pkg::ST_FAULT;
                else
                begin
                    word_mem[slot*LINE_WORDS + word_i]     = data;
                    word_written[slot*LINE_WORDS + word_i] = 1'b1;
                    if (word_i == LINE_WORDS - 1)
                    begin
                        tag_mem[slot]    = refill_tag;
                        line_valid[slot] = 1'b1;
                        r.status         = saic_pkg::ST_FILLED;
                    end
                    else
                        r.status = saic_pkg::ST_ACCEPT;
                end
            end
            saic_pkg::MODE_FLUSH_ALL:
            begin
                for (int i = 0; i < NUM_LINES; i++)
                    line_valid[i] = 1'b0;
            end
            default:
            begin
                for (int w = 0; w < saic_pkg::NUM_WAYS; w++)
                begin
                    slot = int'(lno[saic_pkg::SET_W-1:0]) * saic_pkg::NUM_WAYS + w;
                    if (line_valid[slot] && tag_mem[slot] == lno)
                        line_valid[slot] = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pool_address();
        logic [31:0] a;
        a        = $urandom;
        a[31:10] = tag_bases[2'($urandom_range(0, 3))];
        if ($urandom_range(0, 3) != 0)
            a[9:5] = 5'($urandom_range(0, 3));
        return a;
    endfunction

    task automatic send_item(saic_pkg::mode_t m, logic [31:0] addr, logic [31:0] data,
                             logic err, logic typed, response_t fixed);
        response_t got;
        if (m == saic_pkg::MODE_FETCH && hits_unwritten_word(addr))
            m = saic_pkg::MODE_FLUSH_LINE;
        in_bus.valid      <= 1'b1;
        in_bus.mode       <= m;
        in_bus.address    <= addr;
        in_bus.fill_data  <= data;
        in_bus.fill_error <= err;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
        got         = predict_response(m, addr, data, err);
        last_status = got.status;
        expected_responses.push_back(typed ? fixed : got);
        n_sent++;
    endtask

    task automatic sender_pause();
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16))
                @(posedge clk);
        end
    endtask

    task automatic send_random(saic_pkg::mode_t m, logic [31:0] addr, logic err);
        sender_pause();
        send_item(m, addr, $urandom, err, 1'b0, '0);
    endtask

    // Refill after a miss: mostly in order and complete, sometimes with a
    // fault, a skipped word or shuffled offsets.
    task automatic refill_line();
        int          skip;
        bit          shuffle;
        logic [31:0] a;
        logic        err;
        skip    = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, LINE_WORDS - 2)) : -1;
        shuffle = ($urandom_range(0, 29) == 0);
        for (int w = 0; w < LINE_WORDS; w++)
        begin
            if (w != skip)
            begin
                a      = $urandom;
                a[4:2] = shuffle ? 3'($urandom_range(0, LINE_WORDS - 1)) : 3'(w);
                err    = ($urandom_range(0, 39) == 0);
                send_random(saic_pkg::MODE_FILL, a, err);
                if (err)
                    break;
            end
        end
    endtask

    always @(posedge clk)
    begin
        response_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (expected_responses.size() == 0)
            begin
                $error("response transaction with no expectation: status %0d",
                       out_bus.status);
                errors++;
            end
            else
            begin
                want = expected_responses.pop_front();
                if (out_bus.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, out_bus.status);
                    errors++;
                end
                if (out_bus.instruction !== want.instruction)
                begin
                    $error("instruction expected %08h actual %08h",
                           want.instruction, out_bus.instruction);
                    errors++;
                end
                if (out_bus.victim_way !== want.victim_way)
                begin
                    $error("victim_way expected %0d actual %0d",
                           want.victim_way, out_bus.victim_way);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        out_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!held_off && n_sent >= PRESSURE_AT)
            begin
                held_off = 1'b1;
                out_bus.ready <= 1'b0;
                repeat (PRESSURE_HOLD)
                    @(posedge clk);
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                out_bus.ready <= 1'b0;
                repeat ($urandom_range(0, 15))
                    @(posedge clk);
            end
            else
                out_bus.ready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned total;
        int          pick;
        step_t       row;
        logic [31:0] a;
        rst_n             <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.mode       <= saic_pkg::MODE_FETCH;
        in_bus.address    <= '0;
        in_bus.fill_data  <= '0;
        in_bus.fill_error <= 1'b0;
        n_sent            = 0;
        idle_pct          = 10;
        last_status       = saic_pkg::ST_FLUSHED;
        tag_bases[0]      = '0;
        tag_bases[1]      = '1;
        tag_bases[2]      = 22'($urandom);
        tag_bases[3]      = 22'($urandom);
        clear_cache_model();
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED_STEPS[i];
            sender_pause();
            send_item(row.mode, row.address, row.fill_data, row.fill_error, row.typed,
                      '{status: row.status, instruction: row.instruction,
                        victim_way: row.victim_way});
        end

        total = DIRECTED_ROWS + RANDOM_ITEMS;
        while (n_sent < total)
        begin
            if (n_sent + CALM_TAIL >= total)
                idle_pct = 0;
            else if (n_sent % 200 < 3)
                idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                a = (pick < 70) ? pool_address() : $urandom;
                send_random(saic_pkg::MODE_FETCH, a, 1'b0);
                if (last_status == saic_pkg::ST_MISS && $urandom_range(0, 9) != 0)
                    refill_line();
            end
            else if (pick < 87)
                send_random(saic_pkg::MODE_FILL, $urandom, 1'($urandom_range(0, 1)));
            else if (pick < 94)
                send_random(saic_pkg::MODE_FLUSH_LINE, pool_address(), 1'b0);
            else if (pick < 96)
                send_random(saic_pkg::MODE_FLUSH_ALL, $urandom, 1'($urandom_range(0, 1)));
            else
                send_random(saic_pkg::mode_t'($urandom_range(0, 3)), $urandom,
                            1'($urandom_range(0, 1)));
        end
        in_bus.valid <= 1'b0;

        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
